// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the bit sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/pwlbs_pkg.sv
// Types, codes and reset values for the pulse width light bit sender.
`default_nettype none
package pwlbs_pkg;

   localparam int MsgDepthDefault = 32;

   localparam int HalfBitWidth   = 20;
   localparam int CarrierWidth   = 8;
   localparam int TicksLeftWidth = 21;
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 20;

   localparam logic [HalfBitWidth-1:0] HalfBitReset       = 20'd500;
   localparam logic [CarrierWidth-1:0] CarrierPeriodReset = 8'd26;
   localparam logic [CarrierWidth-1:0] CarrierHighReset   = 8'd13;

   localparam logic [CsrIndexWidth-1:0] CSR_HALF_BIT_TICKS       = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CARRIER_PERIOD_TICKS = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CARRIER_HIGH_TICKS   = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_MARK  = 2'd1,
      PH_SPACE = 2'd2
   } phase_type;

endpackage
`default_nettype wire

// File: rtl/pwlbs_store.sv
// Message byte memory with a registered read and write-to-read forwarding.
`default_nettype none
module pwlbs_store
   import pwlbs_pkg::*;
#(
   parameter int MSG_DEPTH = MsgDepthDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MSG_DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]                   wr_data,
   input  wire logic [$clog2(MSG_DEPTH)-1:0] rd_addr,
   output logic      [7:0]                   rd_data
);

   logic [7:0] mem [MSG_DEPTH];
   logic [7:0] rd_data_ff;
   logic [7:0] fwd_data_ff;
   logic       fwd_hit_ff;
   logic       fwd_hit_in;

   assign fwd_hit_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/pulse_width_light_bit_sender_core.sv
// Top level of the pulse width light bit sender.
//
//   channel | direction | beat fields                              | handshake
//   req_    | in        | cmd, data_byte, last_byte                | valid / stall
//   rsp_    | out       | led_drive, mark_active, busy_res, accepted | valid / stall
//   csr_    | in        | index, wdata                             | wr_en, no wait
//
// One request beat is taken per cycle while req_stall is low; each gives one registered response beat.
// The response register frees on the cycle it is taken, so req_ stalls only while a valid response meets rsp_stall.
// The byte memory is read ahead of use; the next byte is prefetched while bits run.
// Synchronous active-high reset clears control state and restores register defaults.
`default_nettype none
`include "assert_macros.svh"
module pulse_width_light_bit_sender_core
   import pwlbs_pkg::*;
#(
   parameter int MSG_DEPTH = MsgDepthDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_cmd,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_last_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_led_drive,
   output logic                          rsp_mark_active,
   output logic                          rsp_busy_res,
   output logic                          rsp_accepted,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam int AW = $clog2(MSG_DEPTH);
   localparam int CW = $clog2(MSG_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(MSG_DEPTH);

   logic [HalfBitWidth-1:0]   half_bit_ff;
   logic [CarrierWidth-1:0]   car_period_ff;
   logic [CarrierWidth-1:0]   car_high_ff;

   phase_type                 phase_ff, phase_in;
   logic [CW-1:0]             byte_count_ff, byte_count_in;
   logic [CW-1:0]             read_pos_ff, read_pos_in;
   logic [2:0]                bit_pos_ff, bit_pos_in;
   logic [TicksLeftWidth-1:0] ticks_left_ff, ticks_left_in;
   logic [CarrierWidth-1:0]   car_count_ff, car_count_in;
   logic [7:0]                cur_byte_ff, cur_byte_in;

   logic                      rsp_valid_ff;
   logic                      rsp_led_ff, rsp_led_in;
   logic                      rsp_mark_ff, rsp_mark_in;
   logic                      rsp_busy_ff, rsp_busy_in;
   logic                      rsp_acc_ff, rsp_acc_in;

   logic                      req_accept;
   logic                      store_wr_en;
   logic [AW-1:0]             store_rd_addr;
   logic [7:0]                store_rd_data;
   logic [CW-1:0]             read_pos_inc;
   logic [TicksLeftWidth-1:0] half_len;
   logic [TicksLeftWidth-1:0] ticks_dec;
   logic [CarrierWidth:0]     car_inc;
   logic                      byte_wrap;
   logic [2:0]                bit_next;
   logic [CW-1:0]             read_pos_next;
   logic [7:0]                sel_byte;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign read_pos_inc  = read_pos_ff + CW'(1);
   assign store_wr_en   = req_accept && (req_cmd == CMD_WRITE) && (phase_ff == PH_IDLE)
                          && (byte_count_ff < DEPTH_C);
   assign store_rd_addr = (phase_ff == PH_IDLE) ? AW'(0) : read_pos_inc[AW-1:0];

   pwlbs_store #(
      .MSG_DEPTH(MSG_DEPTH)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (store_wr_en),
      .wr_addr(byte_count_ff[AW-1:0]),
      .wr_data(req_data_byte),
      .rd_addr(store_rd_addr),
      .rd_data(store_rd_data)
   );

   assign half_len  = (half_bit_ff == '0) ? TicksLeftWidth'(1) : {1'b0, half_bit_ff};
   assign ticks_dec = (ticks_left_ff != '0) ? ticks_left_ff - TicksLeftWidth'(1)
                                            : ticks_left_ff;
   assign car_inc   = {1'b0, car_count_ff} + (CarrierWidth + 1)'(1);
   assign byte_wrap = (bit_pos_ff == 3'd7);
   assign bit_next  = bit_pos_ff + 3'd1;
   assign read_pos_next = byte_wrap ? read_pos_inc : read_pos_ff;

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      read_pos_in   = read_pos_ff;
      bit_pos_in    = bit_pos_ff;
      ticks_left_in = ticks_left_ff;
      car_count_in  = car_count_ff;
      cur_byte_in   = cur_byte_ff;
      rsp_led_in    = 1'b0;
      rsp_mark_in   = 1'b0;
      rsp_busy_in   = 1'b0;
      rsp_acc_in    = 1'b0;
      sel_byte      = cur_byte_ff;
      if (req_accept) begin
         if (req_cmd == CMD_WRITE) begin
            rsp_busy_in = (phase_ff != PH_IDLE);
            if (phase_ff == PH_IDLE) begin
               if (byte_count_ff < DEPTH_C) begin
                  byte_count_in = byte_count_ff + CW'(1);
                  rsp_acc_in    = 1'b1;
               end
               if (req_last_byte) begin
                  sel_byte      = (byte_count_ff == '0) ? req_data_byte : store_rd_data;
                  cur_byte_in   = sel_byte;
                  read_pos_in   = '0;
                  bit_pos_in    = '0;
                  phase_in      = PH_MARK;
                  car_count_in  = '0;
                  ticks_left_in = sel_byte[7] ? {half_len[TicksLeftWidth-2:0], 1'b0}
                                              : half_len;
                  rsp_busy_in   = 1'b1;
               end
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_MARK: begin
                  rsp_busy_in   = 1'b1;
                  rsp_mark_in   = 1'b1;
                  rsp_led_in    = (car_count_ff < car_high_ff);
                  car_count_in  = (car_inc >= {1'b0, car_period_ff}) ? '0
                                                                      : car_inc[CarrierWidth-1:0];
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     phase_in      = PH_SPACE;
                     ticks_left_in = half_len;
                     car_count_in  = '0;
                  end
               end
               PH_SPACE: begin
                  rsp_busy_in   = 1'b1;
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     if (read_pos_next >= byte_count_ff) begin
                        phase_in      = PH_IDLE;
                        byte_count_in = '0;
                        read_pos_in   = '0;
                        bit_pos_in    = '0;
                        ticks_left_in = '0;
                        car_count_in  = '0;
                     end else begin
                        sel_byte      = byte_wrap ? store_rd_data : cur_byte_ff;
                        cur_byte_in   = sel_byte;
                        read_pos_in   = read_pos_next;
                        bit_pos_in    = bit_next;
                        phase_in      = PH_MARK;
                        car_count_in  = '0;
                        ticks_left_in = sel_byte[~bit_next]
                                        ? {half_len[TicksLeftWidth-2:0], 1'b0} : half_len;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff   <= HalfBitReset;
         car_period_ff <= CarrierPeriodReset;
         car_high_ff   <= CarrierHighReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HALF_BIT_TICKS:       half_bit_ff   <= csr_wdata[HalfBitWidth-1:0];
            CSR_CARRIER_PERIOD_TICKS: car_period_ff <= csr_wdata[CarrierWidth-1:0];
            CSR_CARRIER_HIGH_TICKS:   car_high_ff   <= csr_wdata[CarrierWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_count_ff <= '0;
         read_pos_ff   <= '0;
         bit_pos_ff    <= '0;
         ticks_left_ff <= '0;
         car_count_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         read_pos_ff   <= read_pos_in;
         bit_pos_ff    <= bit_pos_in;
         ticks_left_ff <= ticks_left_in;
         car_count_ff  <= car_count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
      if (req_accept) begin
         rsp_led_ff  <= rsp_led_in;
         rsp_mark_ff <= rsp_mark_in;
         rsp_busy_ff <= rsp_busy_in;
         rsp_acc_ff  <= rsp_acc_in;
      end
   end

   // hold the response beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_drive   = rsp_led_ff;
   assign rsp_mark_active = rsp_mark_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_accepted    = rsp_acc_ff;

   `ASSERT_ALWAYS(a_count_in_range, clock, reset, byte_count_ff <= DEPTH_C)
   `ASSERT_IMPLIES(a_busy_has_bytes, clock, reset, phase_ff != PH_IDLE, read_pos_ff < byte_count_ff)
   `ASSERT_IMPLIES(a_idle_cleared, clock, reset, phase_ff == PH_IDLE, (read_pos_ff == '0) && (bit_pos_ff == '0))
   `ASSERT_IMPLIES(a_led_in_mark, clock, reset, rsp_valid_ff && rsp_led_ff, rsp_mark_ff)
   `ASSERT_NEXT(a_busy_write_refused, clock, reset, req_accept && (req_cmd == CMD_WRITE) && (phase_ff != PH_IDLE), rsp_valid_ff && !rsp_acc_ff && rsp_busy_ff)

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the pulse width light bit sender core: directed table, random messages, long half bit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pwlbs_pkg::*;

   localparam int MsgDepth       = MsgDepthDefault;
   localparam int CountWidth     = $clog2(MsgDepth + 1);
   localparam int IndexWidth     = $clog2(MsgDepth);
   localparam int CycleLimit     = 300000;
   localparam int SettleCycles   = 4;
   localparam int MixCount       = 7;
   localparam int BeatsPerMix    = 40;
   localparam int LongTicks      = 20;
   localparam int ExpectDepth    = 16;
   localparam int ExpectPtrWidth = $clog2(ExpectDepth);
   localparam int PlanRows       = 25;
   localparam int PlanIdxWidth   = $clog2(PlanRows);

   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic led_drive;
      logic mark_active;
      logic busy_res;
      logic accepted;
   } sender_result_type;

   localparam sender_result_type QuietResult = 4'b0000;
   localparam sender_result_type StoredIdle  = 4'b0001;
   localparam sender_result_type StoredBusy  = 4'b0011;
   localparam sender_result_type RefusedBusy = 4'b0010;
   localparam sender_result_type MarkLit     = 4'b1110;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_REGS,
      ROW_FLUSH
   } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic                     cmd;
      logic [7:0]               data;
      logic                     last;
      logic                     typed;
      sender_result_type        want;
      logic [HalfBitWidth-1:0]  half;
      logic [CarrierWidth-1:0]  period;
      logic [CarrierWidth-1:0]  high;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_cmd = CMD_WRITE;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_led_drive;
   logic                     rsp_mark_active;
   logic                     rsp_busy_res;
   logic                     rsp_accepted;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   pulse_width_light_bit_sender_core #(
      .MSG_DEPTH(MsgDepth)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_led_drive   (rsp_led_drive),
      .rsp_mark_active (rsp_mark_active),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_accepted    (rsp_accepted),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state
   logic [HalfBitWidth-1:0]   half_bit_reg       = HalfBitReset;
   logic [CarrierWidth-1:0]   carrier_period_reg = CarrierPeriodReset;
   logic [CarrierWidth-1:0]   carrier_high_reg   = CarrierHighReset;
   logic [7:0]                msg_bytes [0:MsgDepth-1];
   logic [CountWidth-1:0]     fill_count   = '0;
   logic [CountWidth-1:0]     read_index   = '0;
   logic [2:0]                bit_index    = '0;
   phase_type                 tx_phase     = PH_IDLE;
   logic [TicksLeftWidth-1:0] ticks_left   = '0;
   logic [CarrierWidth-1:0]   carrier_tick = '0;

   sender_result_type         expect_buf [0:ExpectDepth-1];
   logic [ExpectPtrWidth:0]   expect_wr_ptr = '0;
   logic [ExpectPtrWidth:0]   expect_rd_ptr = '0;
   sender_result_type         oldest;
   plan_row_type              plan_rows [0:PlanRows-1];
   logic [PlanIdxWidth-1:0]   plan_len      = '0;
   int                        mismatches    = 0;
   int                        sent_beats    = 0;
   int                        sender_calm   = 0;
   int                        receiver_calm = 0;
   int                        cycle_count   = 0;

   logic [HalfBitWidth-1:0] mix_half [0:MixCount-1] =
      '{20'd1, 20'd0, 20'd2, 20'd1, 20'd1, 20'd2, 20'd3};
   logic [CarrierWidth-1:0] mix_period [0:MixCount-1] =
      '{8'd2, 8'd0, 8'd1, 8'd5, 8'd255, 8'd3, 8'd7};
   logic [CarrierWidth-1:0] mix_high [0:MixCount-1] =
      '{8'd1, 8'd5, 8'd0, 8'd200, 8'd255, 8'd2, 8'd3};

   function automatic logic [ExpectPtrWidth:0] expect_pending();
      return expect_wr_ptr - expect_rd_ptr;
   endfunction

   function automatic void add_row(input plan_row_type row);
      plan_rows[plan_len] = row;
      plan_len++;
   endfunction

   function automatic logic [TicksLeftWidth-1:0] half_span();
      return (half_bit_reg == '0) ? TicksLeftWidth'(1) : TicksLeftWidth'(half_bit_reg);
   endfunction

   function automatic void load_mark();
      logic [7:0] cur;
      cur          = (read_index < MsgDepth) ? msg_bytes[read_index[IndexWidth-1:0]] : 8'h00;
      tx_phase     = PH_MARK;
      carrier_tick = '0;
      ticks_left   = cur[3'd7 - bit_index] ? (half_span() << 1) : half_span();
   endfunction

   function automatic sender_result_type advance_sender(input logic cmd, input logic [7:0] data,
                                                        input logic last);
      sender_result_type r;
      r = QuietResult;
      if (cmd == CMD_WRITE) begin
         if (tx_phase == PH_IDLE) begin
            if (fill_count < MsgDepth) begin
               msg_bytes[fill_count[IndexWidth-1:0]] = data;
               fill_count++;
               r.accepted = 1'b1;
            end
            if (last && fill_count != 0) begin
               read_index = '0;
               bit_index  = '0;
               load_mark();
            end
         end
         r.busy_res = (tx_phase != PH_IDLE);
      end else if (tx_phase == PH_MARK) begin
         r.busy_res    = 1'b1;
         r.mark_active = 1'b1;
         r.led_drive   = (carrier_tick < carrier_high_reg);
         if ({1'b0, carrier_tick} + 9'd1 >= {1'b0, carrier_period_reg}) begin
            carrier_tick = '0;
         end else begin
            carrier_tick++;
         end
         if (ticks_left != 0) ticks_left--;
         if (ticks_left == 0) begin
            tx_phase     = PH_SPACE;
            ticks_left   = half_span();
            carrier_tick = '0;
         end
      end else if (tx_phase == PH_SPACE) begin
         r.busy_res = 1'b1;
         if (ticks_left != 0) ticks_left--;
         if (ticks_left == 0) begin
            if (bit_index == 3'd7) begin
               bit_index = '0;
               read_index++;
            end else begin
               bit_index++;
            end
            if (read_index >= fill_count) begin
               tx_phase     = PH_IDLE;
               fill_count   = '0;
               read_index   = '0;
               bit_index    = '0;
               ticks_left   = '0;
               carrier_tick = '0;
            end else begin
               load_mark();
            end
         end
      end
      return r;
   endfunction

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 10);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic plan_row_type beat_row(input logic cmd, input logic [7:0] data,
                                             input logic last);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_BEAT;
      row.cmd  = cmd;
      row.data = data;
      row.last = last;
      return row;
   endfunction

   function automatic plan_row_type typed_row(input logic cmd, input logic [7:0] data,
                                              input logic last, input sender_result_type want);
      plan_row_type row;
      row       = beat_row(cmd, data, last);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic plan_row_type regs_row(input logic [HalfBitWidth-1:0] half,
                                             input logic [CarrierWidth-1:0] period,
                                             input logic [CarrierWidth-1:0] high);
      plan_row_type row;
      row        = '0;
      row.kind   = ROW_REGS;
      row.half   = half;
      row.period = period;
      row.high   = high;
      return row;
   endfunction

   function automatic plan_row_type flush_row();
      plan_row_type row;
      row      = '0;
      row.kind = ROW_FLUSH;
      return row;
   endfunction

   task automatic push_beat(input logic cmd, input logic [7:0] data, input logic last,
                            input logic typed, input sender_result_type want);
      int                gap;
      sender_result_type predicted;
      gap = draw_wait(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_sender(cmd, data, last);
      expect_buf[expect_wr_ptr[ExpectPtrWidth-1:0]] = typed ? want : predicted;
      expect_wr_ptr = expect_wr_ptr + 1'b1;
      sent_beats++;
      @(negedge clock);
   endtask

   task automatic tick_once();
      push_beat(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                QuietResult);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expect_pending() != '0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic program_regs(input logic [HalfBitWidth-1:0] half,
                               input logic [CarrierWidth-1:0] period,
                               input logic [CarrierWidth-1:0] high);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HALF_BIT_TICKS;
      csr_wdata <= CsrDataWidth'(half);
      @(negedge clock);
      csr_index <= CSR_CARRIER_PERIOD_TICKS;
      csr_wdata <= CsrDataWidth'(period);
      @(negedge clock);
      csr_index <= CSR_CARRIER_HIGH_TICKS;
      csr_wdata <= CsrDataWidth'(high);
      @(negedge clock);
      // index past the list: must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= CsrDataWidth'($urandom_range(0, (1 << CsrDataWidth) - 1));
      @(negedge clock);
      csr_wr_en          <= 1'b0;
      half_bit_reg       = half;
      carrier_period_reg = period;
      carrier_high_reg   = high;
      @(negedge clock);
   endtask

   task automatic finish_message(input logic noisy);
      while (tx_phase != PH_IDLE) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            push_beat(CMD_WRITE, pick_byte(), 1'($urandom_range(0, 1)), 1'b0, QuietResult);
         end else begin
            tick_once();
         end
      end
   endtask

   task automatic send_message(input int nbytes);
      for (int i = 0; i < nbytes; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0) tick_once();
         push_beat(CMD_WRITE, pick_byte(), i == nbytes - 1, 1'b0, QuietResult);
      end
      finish_message(1'b1);
   endtask

   task automatic compare_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expect_pending() == '0) begin
            $error("result beat with no expectation pending");
            mismatches++;
         end else begin
            oldest = expect_buf[expect_rd_ptr[ExpectPtrWidth-1:0]];
            expect_rd_ptr = expect_rd_ptr + 1'b1;
            compare_field("led_drive", oldest.led_drive, rsp_led_drive);
            compare_field("mark_active", oldest.mark_active, rsp_mark_active);
            compare_field("busy_res", oldest.busy_res, rsp_busy_res);
            compare_field("accepted", oldest.accepted, rsp_accepted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("pulse_width_light_bit_sender_core verification failed");
         $finish;
      end
   end

   initial begin
      int n;
      int taken;
      taken = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         n = draw_wait(receiver_calm);
         // hold off long enough to back the block up
         if (taken == 300 || taken == 900) n = 80;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      int mark_beats;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_row(typed_row(CMD_TICK, 8'h00, 1'b0, QuietResult));
      add_row(regs_row(20'd3, CarrierPeriodReset, CarrierHighReset));
      add_row(typed_row(CMD_WRITE, 8'h00, 1'b0, StoredIdle));
      add_row(typed_row(CMD_WRITE, 8'h00, 1'b1, StoredBusy));
      add_row(typed_row(CMD_TICK, 8'hFF, 1'b1, MarkLit));
      add_row(typed_row(CMD_TICK, 8'h00, 1'b0, MarkLit));
      add_row(typed_row(CMD_TICK, 8'hFF, 1'b1, MarkLit));
      add_row(typed_row(CMD_WRITE, 8'hFF, 1'b1, RefusedBusy));
      add_row(regs_row(20'd1, 8'd2, 8'd1));
      add_row(flush_row());
      add_row(regs_row(20'd0, 8'd0, 8'd5));
      add_row(beat_row(CMD_WRITE, 8'h80, 1'b1));
      add_row(beat_row(CMD_TICK, 8'h00, 1'b0));
      add_row(beat_row(CMD_TICK, 8'hFF, 1'b1));
      add_row(beat_row(CMD_TICK, 8'h00, 1'b0));
      add_row(beat_row(CMD_TICK, 8'hFF, 1'b1));
      add_row(beat_row(CMD_WRITE, 8'h7F, 1'b0));
      add_row(flush_row());
      add_row(regs_row(20'd2, 8'd3, 8'd255));
      add_row(typed_row(CMD_WRITE, 8'hFF, 1'b0, StoredIdle));
      add_row(beat_row(CMD_WRITE, 8'h01, 1'b1));
      add_row(flush_row());
      add_row(regs_row(20'd1, 8'd255, 8'd0));
      add_row(beat_row(CMD_WRITE, 8'hC3, 1'b1));
      add_row(flush_row());

      foreach (plan_rows[k]) begin
         case (plan_rows[k].kind)
            ROW_BEAT: begin
               push_beat(plan_rows[k].cmd, plan_rows[k].data, plan_rows[k].last,
                         plan_rows[k].typed, plan_rows[k].want);
            end
            ROW_REGS: begin
               program_regs(plan_rows[k].half, plan_rows[k].period, plan_rows[k].high);
            end
            default: begin
               finish_message(1'b0);
            end
         endcase
      end

      for (int i = 0; i <= MixCount; i++) begin
         if (i < MixCount) begin
            program_regs(mix_half[i], mix_period[i], mix_high[i]);
         end else begin
            program_regs(HalfBitWidth'($urandom_range(1, 2)),
                         CarrierWidth'($urandom_range(0, 9)),
                         CarrierWidth'($urandom_range(0, 10)));
         end
         mark_beats = sent_beats;
         // overfill the store so the closing byte is refused
         if (i == 1) send_message($urandom_range(MsgDepth + 1, MsgDepth + 3));
         while (sent_beats - mark_beats < BeatsPerMix) begin
            if ($urandom_range(0, 19) == 0) begin
               send_message($urandom_range(4, 12));
            end else begin
               send_message($urandom_range(1, 3));
            end
         end
      end

      // longest half bit: the message cannot finish, so just watch its start
      program_regs(20'hFFFFF, 8'd26, 8'd13);
      push_beat(CMD_WRITE, pick_byte(), 1'b1, 1'b0, QuietResult);
      repeat (LongTicks) tick_once();
      push_beat(CMD_WRITE, pick_byte(), 1'b1, 1'b0, QuietResult);
      settle();

      if (mismatches == 0) begin
         $display("pulse_width_light_bit_sender_core verification clean");
      end else begin
         $display("pulse_width_light_bit_sender_core verification failed");
      end
      $finish;
   end

endmodule
